// ===== rtl/core/lsd_pkg.sv =====
`timescale 1ns / 1ps

package lsd_pkg;

  // Operation codes carried by in_mode
  localparam logic [2:0] MODE_PUSH         = 3'd0;
  localparam logic [2:0] MODE_POP          = 3'd1;
  localparam logic [2:0] MODE_TOP          = 3'd2;
  localparam logic [2:0] MODE_CLEAR        = 3'd3;
  localparam logic [2:0] MODE_PRINT        = 3'd4;
  localparam logic [2:0] MODE_SILENT_CLEAR = 3'd5;

  // Result status codes
  localparam logic [1:0] STAT_VALID = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam int unsigned WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  // Shift command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_DOWN,
    SH_UP
  } shift_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PRINT
  } state_t;

endpackage

// ===== rtl/core/lsd_cell.sv =====
`timescale 1ns / 1ps

module lsd_cell
  import lsd_pkg::*;
(
  input  logic   clk,
  input  shift_t shift,
  input  word_t  down_in,
  input  word_t  up_in,
  output word_t  word
);

  word_t word_r;
  word_t word_nxt;

  // Take the word of the neighbor above on a push, below on a pop or rotate.
  always_comb begin
    unique case (shift)
      SH_DOWN: word_nxt = down_in;
      SH_UP:   word_nxt = up_in;
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// ===== rtl/core/lsd_chain.sv =====
`timescale 1ns / 1ps

module lsd_chain
  import lsd_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic   clk,
  input  shift_t shift,
  input  word_t  push_value,
  output word_t  top_word
);

  word_t words [DEPTH];

  // Cell 0 is the top of the stack. The bottom cell wraps to cell 0 so that an
  // upward shift of DEPTH steps returns the chain to where it started.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t down_in;
    word_t up_in;

    if (i == 0) begin : g_first
      assign down_in = push_value;
    end else begin : g_mid_dn
      assign down_in = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign up_in = words[0];
    end else begin : g_mid_up
      assign up_in = words[i+1];
    end

    lsd_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .down_in (down_in),
      .up_in   (up_in),
      .word    (words[i])
    );
  end

  assign top_word = words[0];

endmodule

// ===== rtl/core/lifo_stack_with_dump.sv =====
`timescale 1ns / 1ps

// LIFO stack of DEPTH signed 32-bit words built as a row of shift cells, cell 0
// holding the top. Push moves every word one cell down and writes cell 0, pop
// moves every word one cell up, so no addressing is needed. Each operation is
// accepted in S_IDLE and executed in S_EXEC; one that owes a result waits in
// S_EXEC while a stalled result holds the output register. Print then rotates
// the chain a full circle through its wrap path in S_PRINT, one cell per cycle
// while no due word meets a stalled output, and cell 0 is sent out on each of
// the first fill-count steps, the final one marked with out_last. An empty
// stack answers pop, top, print and clear with one empty-status result; a push
// onto a full stack is dropped with a full status.
// No clearing pass follows reset: stored words are never read before written.
module lifo_stack_with_dump
  import lsd_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_mode,
  input  logic signed [WORD_W-1:0] in_push_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic signed [WORD_W-1:0] out_value,
  output logic                     out_last
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   step_r, step_nxt;
  logic [2:0]         mode_r;
  word_t              value_r;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  word_t              out_value_r;
  logic               out_last_r;

  shift_t             shift;
  word_t              top_word;
  logic               slot_free;
  logic               in_xfer;
  logic               load;
  logic [1:0]         ld_status;
  word_t              ld_value;
  logic               ld_last;
  logic               empty;
  logic               full;
  logic               emit;

  lsd_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk        (clk),
    .shift      (shift),
    .push_value (value_r),
    .top_word   (top_word)
  );

  // Accept one transfer at a time; the item then executes in S_EXEC.
  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  // The output register can take a new result this cycle.
  assign slot_free = !out_valid_r || !out_stall;
  assign empty     = (count_r == '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  // During print, steps below the fill count send a word; the rest only rotate.
  assign emit      = (CNT_W'(step_r) < count_r);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    step_nxt  = step_r;
    shift     = SH_HOLD;
    load      = 1'b0;
    ld_status = STAT_VALID;
    ld_value  = '0;
    ld_last   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (mode_r)
          MODE_PUSH: begin
            if (full) begin
              // Drop the word and report; wait for room in the output register.
              if (slot_free) begin
                load      = 1'b1;
                ld_status = STAT_FULL;
                state_nxt = S_IDLE;
              end
            end else begin
              shift     = SH_DOWN;
              count_nxt = count_r + 1'b1;
              state_nxt = S_IDLE;
            end
          end
          MODE_POP: begin
            if (slot_free) begin
              load      = 1'b1;
              state_nxt = S_IDLE;
              if (empty) begin
                ld_status = STAT_EMPTY;
              end else begin
                ld_value  = top_word;
                shift     = SH_UP;
                count_nxt = count_r - 1'b1;
              end
            end
          end
          MODE_TOP: begin
            if (slot_free) begin
              load      = 1'b1;
              state_nxt = S_IDLE;
              if (empty) begin
                ld_status = STAT_EMPTY;
              end else begin
                ld_value  = top_word;
              end
            end
          end
          MODE_CLEAR: begin
            if (empty) begin
              if (slot_free) begin
                load      = 1'b1;
                ld_status = STAT_EMPTY;
                state_nxt = S_IDLE;
              end
            end else begin
              count_nxt = '0;
              state_nxt = S_IDLE;
            end
          end
          MODE_PRINT: begin
            if (empty) begin
              if (slot_free) begin
                load      = 1'b1;
                ld_status = STAT_EMPTY;
                state_nxt = S_IDLE;
              end
            end else begin
              step_nxt  = '0;
              state_nxt = S_PRINT;
            end
          end
          MODE_SILENT_CLEAR: begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end
          default: begin
            // Unused codes: drop silently.
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_PRINT: begin
        // Advance one rotation step unless a word is due and the output is stalled.
        if (!emit || slot_free) begin
          shift    = SH_UP;
          step_nxt = step_r + 1'b1;
          if (emit) begin
            load     = 1'b1;
            ld_value = top_word;
            ld_last  = ((CNT_W'(step_r) + 1'b1) == count_r);
          end
          if (step_r == IDX_W'(DEPTH - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: hold the accepted item and the pending result.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r  <= in_mode;
      value_r <= in_push_value;
    end
    if (load) begin
      out_status_r <= ld_status;
      out_value_r  <= ld_value;
      out_last_r   <= ld_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

`ifndef NO_ASSERTIONS
  // The word count stays within the store.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count exceeds depth");

  // A new result never overwrites one that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a stalled result");

  // The count only moves while an item executes.
  a_count_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |-> ($past(state_r) == S_EXEC))
    else $error("fill count changed outside execution");

  // Print leaves only after the full rotation, with the chain back in place.
  a_print_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PRINT && state_nxt == S_IDLE) |-> (step_r == IDX_W'(DEPTH - 1)))
    else $error("print ended before a full rotation");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import lsd_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int ITEM_TARGET = 480;
  localparam int CYCLE_LIMIT = 1_000_000;

  // Codes the block must ignore: no result, no change to the stack
  localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  typedef struct {
    logic [1:0] status;
    word_t      value;
    logic       last;
  } stack_result_t;

  // Mirror of the stack plus the queue of results still owed by the block
  class lifo_scoreboard;
    word_t         stored_words[STACK_DEPTH];
    int unsigned   fill_level;
    stack_result_t pending_results[$];
    int unsigned   error_count;

    function void expect_result(logic [1:0] status, word_t value, logic last);
      stack_result_t r;
      r.status = status;
      r.value  = value;
      r.last   = last;
      pending_results.push_back(r);
    endfunction

    // Apply one accepted operation and queue the results it owes
    function void note_transfer(logic [2:0] mode, word_t value);
      case (mode)
        MODE_PUSH: begin
          if (fill_level >= STACK_DEPTH) begin
            expect_result(STAT_FULL, '0, 1'b1);
          end else begin
            stored_words[fill_level] = value;
            fill_level++;
          end
        end
        MODE_POP: begin
          if (fill_level == 0) begin
            expect_result(STAT_EMPTY, '0, 1'b1);
          end else begin
            fill_level--;
            expect_result(STAT_VALID, stored_words[fill_level], 1'b1);
          end
        end
        MODE_TOP: begin
          if (fill_level == 0) expect_result(STAT_EMPTY, '0, 1'b1);
          else expect_result(STAT_VALID, stored_words[fill_level-1], 1'b1);
        end
        MODE_CLEAR: begin
          if (fill_level == 0) expect_result(STAT_EMPTY, '0, 1'b1);
          else fill_level = 0;
        end
        MODE_PRINT: begin
          if (fill_level == 0) begin
            expect_result(STAT_EMPTY, '0, 1'b1);
          end else begin
            for (int i = fill_level; i > 0; i--) begin
              expect_result(STAT_VALID, stored_words[i-1], i == 1);
            end
          end
        end
        MODE_SILENT_CLEAR: begin
          fill_level = 0;
        end
        default: begin
        end
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("%0t ns: error in %s: got %h, expected %h", $time, what, got, want);
    endtask

    task check_result(logic [1:0] status, word_t value, logic last);
      stack_result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result value", value, '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report("status", 32'(status), 32'(want.status));
        if (value !== want.value) report("value", value, want.value);
        if (last !== want.last) report("last", 32'(last), 32'(want.last));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_mode = MODE_PUSH;
  word_t             in_push_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  word_t             out_value;
  logic              out_last;

  // Idle odds in percent per cycle, changed between traffic phases
  int                send_idle_pct = 8;
  int                recv_stall_pct = 78;
  int                sent_items;
  int                cycle_count;

  lifo_scoreboard    lifo_sb = new();

  lifo_stack_with_dump #(
    .DEPTH(STACK_DEPTH)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_push_value(in_push_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_value    (out_value),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  // Favor the corner words now and then, otherwise any 32-bit pattern
  function automatic word_t random_word();
    case ($urandom_range(15))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return -1;
      3: return '0;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Offer one operation, idling first at random; hold the payload until the
  // transfer happens, then record it. Valid stays high so a back-to-back
  // operation does not drop it in between.
  task automatic send_op(input logic [2:0] mode, input word_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_push_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lifo_sb.note_transfer(mode, value);
    if (mode <= MODE_SILENT_CLEAR) sent_items++;
  endtask

  // Result side: check every transfer, then stall at random for the next edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      lifo_sb.check_result(out_status, out_value, out_last);
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: give up when the cycle count reaches CYCLE_LIMIT
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int          pick;
    int          roll;
    logic [2:0]  op;
    bit          fill_pending;

    fill_pending = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every empty-stack answer, ignored codes, corner words,
    // dump order, clear and silent clear on a loaded stack
    send_op(MODE_POP, random_word());
    send_op(MODE_TOP, random_word());
    send_op(MODE_PRINT, random_word());
    send_op(MODE_CLEAR, random_word());
    send_op(MODE_SILENT_CLEAR, random_word());
    send_op(MODE_UNUSED_6, WORD_MAX);
    send_op(MODE_UNUSED_7, WORD_MIN);
    send_op(MODE_PUSH, WORD_MAX);
    send_op(MODE_PUSH, WORD_MIN);
    send_op(MODE_PUSH, -1);
    send_op(MODE_PUSH, '0);
    send_op(MODE_UNUSED_7, -1);
    send_op(MODE_TOP, -1);
    send_op(MODE_PRINT, WORD_MAX);
    send_op(MODE_POP, WORD_MIN);
    send_op(MODE_CLEAR, -1);
    send_op(MODE_POP, '0);
    send_op(MODE_PUSH, 32'sh5A5A_5A5A);
    send_op(MODE_PUSH, 32'shA5A5_A5A5);
    send_op(MODE_SILENT_CLEAR, '0);
    send_op(MODE_TOP, '0);

    // Random: mostly well-formed traffic, with full and drained stacks
    while (sent_items < ITEM_TARGET) begin
      if (sent_items >= 2 * ITEM_TARGET / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else if (sent_items >= ITEM_TARGET / 3) begin
        send_idle_pct  = 78;
        recv_stall_pct = 8;
      end
      pick = $urandom_range(99);
      if (fill_pending || pick < 15) begin
        // Fill to the bound, overflow it, then maybe dump, and unwind part way
        fill_pending = 1'b0;
        while (lifo_sb.fill_level < STACK_DEPTH) send_op(MODE_PUSH, random_word());
        repeat ($urandom_range(3, 1)) send_op(MODE_PUSH, random_word());
        if ($urandom_range(1)) send_op(MODE_PRINT, random_word());
        repeat ($urandom_range(8, 1)) send_op(MODE_POP, random_word());
      end else if (pick < 30) begin
        // Drain past empty, then probe the empty stack
        while (lifo_sb.fill_level > 0) send_op(MODE_POP, random_word());
        send_op(MODE_POP, random_word());
        send_op($urandom_range(1) ? MODE_TOP : MODE_PRINT, random_word());
      end else if (pick < 80) begin
        // Push-heavy mix of every operation
        repeat ($urandom_range(20, 5)) begin
          roll = $urandom_range(99);
          if (roll < 45) op = MODE_PUSH;
          else if (roll < 65) op = MODE_POP;
          else if (roll < 77) op = MODE_TOP;
          else if (roll < 85) op = MODE_PRINT;
          else if (roll < 91) op = MODE_CLEAR;
          else if (roll < 96) op = MODE_SILENT_CLEAR;
          else op = roll[0] ? MODE_UNUSED_7 : MODE_UNUSED_6;
          send_op(op, random_word());
        end
      end else begin
        // Noise: any code, any word
        repeat ($urandom_range(10, 3)) send_op(3'($urandom_range(7)), word_t'($urandom));
      end
    end
    in_valid <= 1'b0;

    // Drain: wait out every owed result, then idle before the verdict
    while (lifo_sb.pending_results.size() != 0) @(posedge clk);
    repeat (STACK_DEPTH + 8) @(posedge clk);

    if (lifo_sb.error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
